>>> hdl/wcre_pkg.sv
`default_nettype none
package wcre_pkg;

   localparam int LED_COUNT = 9;

   // input command codes
   localparam logic [2:0] CMD_SET_RANGE   = 3'd0;
   localparam logic [2:0] CMD_SET_DISPLAY = 3'd1;
   localparam logic [2:0] CMD_SET_LED     = 3'd2;
   localparam logic [2:0] CMD_FORCE       = 3'd3;
   localparam logic [2:0] CMD_INIT_LEDS   = 3'd4;
   localparam logic [2:0] CMD_QUERY       = 3'd5;

   // job kinds passed from front to back
   localparam logic [2:0] KIND_RANGE   = 3'd0;
   localparam logic [2:0] KIND_DISPLAY = 3'd1;
   localparam logic [2:0] KIND_LED     = 3'd2;
   localparam logic [2:0] KIND_FORCE   = 3'd3;
   localparam logic [2:0] KIND_STOP    = 3'd4;
   localparam logic [2:0] KIND_INIT    = 3'd5;
   localparam logic [2:0] KIND_QUERY   = 3'd6;

   // configuration register indexes
   localparam logic CSR_LOW_LIMIT  = 1'b0;
   localparam logic CSR_HIGH_LIMIT = 1'b1;

   localparam logic [15:0] LOW_LIMIT_RESET  = 16'd90;
   localparam logic [15:0] HIGH_LIMIT_RESET = 16'd1080;

   // report byte codes
   localparam logic [7:0] RPT_RANGE_PREP = 8'hf5;
   localparam logic [7:0] RPT_EXT        = 8'hf8;
   localparam logic [7:0] SUB_SETUP      = 8'h09;
   localparam logic [7:0] SUB_RANGE      = 8'h81;
   localparam logic [7:0] SUB_INIT_A     = 8'h13;
   localparam logic [7:0] SUB_INIT_B     = 8'h14;
   localparam logic [7:0] SUB_FORCE      = 8'h08;
   localparam logic [7:0] RPT_FORCE      = 8'h01;
   localparam logic [7:0] RPT_STOP       = 8'h03;
   localparam logic [7:0] FORCE_NEUTRAL  = 8'h80;
   localparam logic [7:0] BYTE_ONES      = 8'hff;
   localparam logic [7:0] SETUP_DISPLAY  = 8'h01;
   localparam logic [7:0] SETUP_DIGITS   = 8'h02;
   localparam logic [7:0] SETUP_RANGE_A  = 8'h06;
   localparam logic [7:0] SETUP_LED      = 8'h08;
   localparam logic [7:0] SETUP_LED_INIT = 8'h02;
   localparam logic [7:0] BYTE_ONE       = 8'h01;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  p0;
      logic [7:0]  p1;
      logic [7:0]  p2;
      logic [15:0] cur_range;
      logic [8:0]  mask;
   } job_type;

   function automatic logic [7:0] seg_code(input logic [3:0] d);
      logic [7:0] s;
      unique case (d)
         4'd0:    s = 8'h3f;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5b;
         4'd3:    s = 8'h4f;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6d;
         4'd6:    s = 8'h7d;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7f;
         4'd9:    s = 8'h67;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   // index of the final report of a job
   function automatic logic [1:0] last_step(input logic [2:0] kind);
      logic [1:0] n;
      unique case (kind)
         KIND_RANGE: n = 2'd2;
         KIND_INIT:  n = 2'd3;
         default:    n = 2'd0;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

>>> hdl/wcre_front.sv
`default_nettype none
module wcre_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [2:0]        req_command,
   input  wire logic [15:0]       req_range_degrees,
   input  wire logic signed [15:0] req_amount,
   input  wire logic [3:0]        req_led_index,
   input  wire logic              req_led_on,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [15:0]       csr_wdata,
   output logic                   q_push,
   output wcre_pkg::job_type      q_job,
   input  wire logic              q_full
);

   logic [15:0] low_limit_ff, high_limit_ff;
   logic [15:0] range_ff, range_in;
   logic [wcre_pkg::LED_COUNT-1:0] mask_ff, mask_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_kind_ff, s1_kind_in;
   logic [7:0]  s1_p0_ff, s1_p0_in;
   logic [7:0]  s1_p1_ff, s1_p1_in;
   logic        s1_neg_ff;
   logic [14:0] s1_amt_ff;
   logic [11:0] s1_q10_ff, s1_q10_in;
   logic [8:0]  s1_q100_ff, s1_q100_in;
   logic [5:0]  s1_q1000_ff, s1_q1000_in;
   logic [15:0] s1_range_ff;
   logic [8:0]  s1_mask_ff;

   logic        accept, produce;
   logic [15:0] rng_eff;
   logic [15:0] mask16, new16, rev16;
   logic        led_bit;
   logic signed [16:0] force_sum;
   logic [7:0]  force_byte;
   logic [30:0] p10;
   logic [27:0] p100;
   logic [30:0] p1000;
   logic [15:0] ones_w;
   logic [11:0] tens_w;
   logic [8:0]  hund_w;

   assign req_full = s1_valid_ff && q_full;
   assign accept   = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= wcre_pkg::LOW_LIMIT_RESET;
         high_limit_ff <= wcre_pkg::HIGH_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            wcre_pkg::CSR_LOW_LIMIT:  low_limit_ff  <= csr_wdata;
            wcre_pkg::CSR_HIGH_LIMIT: high_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rng_eff = (req_range_degrees == 16'd0) ? high_limit_ff : req_range_degrees;
      mask16  = 16'(mask_ff);
      led_bit = mask16[req_led_index];
      new16   = mask16;
      new16[req_led_index] = req_led_on;
      rev16 = 16'd0;
      for (int i = 0; i < wcre_pkg::LED_COUNT; i++) begin
         rev16[wcre_pkg::LED_COUNT-1-i] = new16[i];
      end

      force_sum = 17'(req_amount) + 17'sd128;
      if (force_sum < 17'sd0) force_byte = 8'h00;
      else if (force_sum > 17'sd255) force_byte = 8'hff;
      else force_byte = force_sum[7:0];

      // reciprocal multiplies, exact for 15-bit magnitudes
      p10   = 31'(req_amount[14:0]) * 31'd52429;
      p100  = 28'(req_amount[14:0]) * 28'd5243;
      p1000 = 31'(req_amount[14:0]) * 31'd33555;
      s1_q10_in   = p10[30:19];
      s1_q100_in  = p100[27:19];
      s1_q1000_in = p1000[30:25];

      range_in   = range_ff;
      mask_in    = mask_ff;
      produce    = 1'b0;
      s1_kind_in = wcre_pkg::KIND_QUERY;
      s1_p0_in   = 8'h00;
      s1_p1_in   = 8'h00;
      unique case (req_command)
         wcre_pkg::CMD_SET_RANGE: begin
            s1_kind_in = wcre_pkg::KIND_RANGE;
            s1_p0_in   = rng_eff[7:0];
            s1_p1_in   = rng_eff[15:8];
            if (!(rng_eff < low_limit_ff) && !(rng_eff > high_limit_ff)) begin
               produce  = 1'b1;
               range_in = rng_eff;
            end
         end
         wcre_pkg::CMD_SET_DISPLAY: begin
            s1_kind_in = wcre_pkg::KIND_DISPLAY;
            produce    = 1'b1;
         end
         wcre_pkg::CMD_SET_LED: begin
            s1_kind_in = wcre_pkg::KIND_LED;
            s1_p0_in   = rev16[15:8];
            s1_p1_in   = rev16[7:0];
            if ((5'(req_led_index) < 5'(wcre_pkg::LED_COUNT)) && (led_bit != req_led_on)) begin
               produce = 1'b1;
               mask_in = new16[wcre_pkg::LED_COUNT-1:0];
            end
         end
         wcre_pkg::CMD_FORCE: begin
            s1_kind_in = (force_byte == wcre_pkg::FORCE_NEUTRAL) ?
                         wcre_pkg::KIND_STOP : wcre_pkg::KIND_FORCE;
            s1_p0_in   = force_byte;
            produce    = 1'b1;
         end
         wcre_pkg::CMD_INIT_LEDS: begin
            s1_kind_in = wcre_pkg::KIND_INIT;
            produce    = 1'b1;
            mask_in    = '0;
         end
         wcre_pkg::CMD_QUERY: begin
            s1_kind_in = wcre_pkg::KIND_QUERY;
            produce    = 1'b1;
         end
         default: ;
      endcase

      if (accept) s1_valid_in = produce;
      else        s1_valid_in = s1_valid_ff && q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         range_ff    <= '0;
         mask_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            range_ff <= range_in;
            mask_ff  <= mask_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= s1_kind_in;
         s1_p0_ff    <= s1_p0_in;
         s1_p1_ff    <= s1_p1_in;
         s1_neg_ff   <= req_amount[15];
         s1_amt_ff   <= req_amount[14:0];
         s1_q10_ff   <= s1_q10_in;
         s1_q100_ff  <= s1_q100_in;
         s1_q1000_ff <= s1_q1000_in;
         s1_range_ff <= range_in;
         s1_mask_ff  <= 9'(16'(mask_in));
      end
   end

   // remainders by shift-add, then segment lookup
   always_comb begin
      ones_w = 16'(s1_amt_ff) - (16'(s1_q10_ff) << 3) - (16'(s1_q10_ff) << 1);
      tens_w = s1_q10_ff - (12'(s1_q100_ff) << 3) - (12'(s1_q100_ff) << 1);
      hund_w = s1_q100_ff - (9'(s1_q1000_ff) << 3) - (9'(s1_q1000_ff) << 1);

      q_job.kind      = s1_kind_ff;
      q_job.p0        = s1_p0_ff;
      q_job.p1        = s1_p1_ff;
      q_job.p2        = 8'h00;
      q_job.cur_range = s1_range_ff;
      q_job.mask      = s1_mask_ff;
      if (s1_kind_ff == wcre_pkg::KIND_DISPLAY) begin
         if (s1_neg_ff) begin
            q_job.p0 = 8'h00;
            q_job.p1 = 8'h00;
         end else begin
            q_job.p0 = wcre_pkg::seg_code(hund_w[3:0]);
            q_job.p1 = wcre_pkg::seg_code(tens_w[3:0]);
            q_job.p2 = wcre_pkg::seg_code(ones_w[3:0]);
         end
      end
   end

   assign q_push = s1_valid_ff;

endmodule
`default_nettype wire

>>> hdl/wcre_queue.sv
`default_nettype none
module wcre_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire wcre_pkg::job_type wr_job,
   output logic              full,
   input  wire logic         pop,
   output wcre_pkg::job_type rd_job,
   output logic              empty
);

   wcre_pkg::job_type entry_ff [wcre_pkg::QUEUE_DEPTH];
   logic [wcre_pkg::QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [wcre_pkg::QUEUE_AW:0]   count_ff;
   logic do_push, do_pop;

   assign full    = (count_ff == (wcre_pkg::QUEUE_AW+1)'(wcre_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_job  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= wr_job;
   end

endmodule
`default_nettype wire

>>> hdl/wcre_back.sv
`default_nettype none
module wcre_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire wcre_pkg::job_type job,
   input  wire logic         job_empty,
   output logic              job_pop,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic [7:0]        rsp_byte0,
   output logic [7:0]        rsp_byte1,
   output logic [7:0]        rsp_byte2,
   output logic [7:0]        rsp_byte3,
   output logic [7:0]        rsp_byte4,
   output logic [7:0]        rsp_byte5,
   output logic [7:0]        rsp_byte6,
   output logic              rsp_is_report,
   output logic              rsp_last,
   output logic [15:0]       rsp_current_range,
   output logic [8:0]        rsp_led_mask
);

   logic       out_valid_ff, out_valid_in;
   logic [1:0] step_ff, step_in;
   logic [7:0] b0_ff, b1_ff, b2_ff, b3_ff, b4_ff, b5_ff, b6_ff;
   logic [7:0] b0_in, b1_in, b2_in, b3_in, b4_in, b5_in, b6_in;
   logic       rep_ff, rep_in, last_ff, last_in;
   logic [15:0] range_ff;
   logic [8:0]  mask_ff;
   logic       load;

   assign load    = !job_empty && (!out_valid_ff || rsp_pop);
   assign last_in = (step_ff == wcre_pkg::last_step(job.kind));
   assign job_pop = load && last_in;

   always_comb begin
      b0_in = 8'h00; b1_in = 8'h00; b2_in = 8'h00; b3_in = 8'h00;
      b4_in = 8'h00; b5_in = 8'h00; b6_in = 8'h00;
      rep_in = 1'b1;
      unique case (job.kind)
         wcre_pkg::KIND_RANGE: begin
            unique case (step_ff)
               2'd0: b0_in = wcre_pkg::RPT_RANGE_PREP;
               2'd1: begin
                  b0_in = wcre_pkg::RPT_EXT;
                  b1_in = wcre_pkg::SUB_SETUP;
                  b2_in = wcre_pkg::BYTE_ONE;
                  b3_in = wcre_pkg::SETUP_RANGE_A;
                  b4_in = wcre_pkg::BYTE_ONE;
               end
               default: begin
                  b0_in = wcre_pkg::RPT_EXT;
                  b1_in = wcre_pkg::SUB_RANGE;
                  b2_in = job.p0;
                  b3_in = job.p1;
               end
            endcase
         end
         wcre_pkg::KIND_DISPLAY: begin
            b0_in = wcre_pkg::RPT_EXT;
            b1_in = wcre_pkg::SUB_SETUP;
            b2_in = wcre_pkg::SETUP_DISPLAY;
            b3_in = wcre_pkg::SETUP_DIGITS;
            b4_in = job.p0;
            b5_in = job.p1;
            b6_in = job.p2;
         end
         wcre_pkg::KIND_LED: begin
            b0_in = wcre_pkg::RPT_EXT;
            b1_in = wcre_pkg::SUB_SETUP;
            b2_in = wcre_pkg::SETUP_LED;
            b3_in = job.p0;
            b4_in = job.p1;
         end
         wcre_pkg::KIND_FORCE: begin
            b0_in = wcre_pkg::RPT_FORCE;
            b1_in = wcre_pkg::SUB_FORCE;
            b2_in = job.p0;
         end
         wcre_pkg::KIND_STOP: begin
            b0_in = wcre_pkg::RPT_STOP;
            b1_in = wcre_pkg::SUB_FORCE;
         end
         wcre_pkg::KIND_INIT: begin
            b0_in = wcre_pkg::RPT_EXT;
            unique case (step_ff)
               2'd0: b1_in = wcre_pkg::SUB_INIT_A;
               2'd1: begin
                  b1_in = wcre_pkg::SUB_INIT_B;
                  b2_in = wcre_pkg::BYTE_ONES;
               end
               2'd2: begin
                  b1_in = wcre_pkg::SUB_SETUP;
                  b2_in = wcre_pkg::SETUP_LED_INIT;
                  b3_in = wcre_pkg::BYTE_ONE;
               end
               default: begin
                  b1_in = wcre_pkg::SUB_SETUP;
                  b2_in = wcre_pkg::SETUP_LED;
                  b3_in = wcre_pkg::BYTE_ONE;
               end
            endcase
         end
         default: rep_in = 1'b0;   // query answer
      endcase

      if (load) step_in = last_in ? 2'd0 : step_ff + 2'd1;
      else      step_in = step_ff;

      if (load)         out_valid_in = 1'b1;
      else if (rsp_pop) out_valid_in = 1'b0;
      else              out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         b0_ff    <= b0_in;
         b1_ff    <= b1_in;
         b2_ff    <= b2_in;
         b3_ff    <= b3_in;
         b4_ff    <= b4_in;
         b5_ff    <= b5_in;
         b6_ff    <= b6_in;
         rep_ff   <= rep_in;
         last_ff  <= last_in;
         range_ff <= job.cur_range;
         mask_ff  <= job.mask;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_byte0         = b0_ff;
   assign rsp_byte1         = b1_ff;
   assign rsp_byte2         = b2_ff;
   assign rsp_byte3         = b3_ff;
   assign rsp_byte4         = b4_ff;
   assign rsp_byte5         = b5_ff;
   assign rsp_byte6         = b6_ff;
   assign rsp_is_report     = rep_ff;
   assign rsp_last          = last_ff;
   assign rsp_current_range = range_ff;
   assign rsp_led_mask      = mask_ff;

endmodule
`default_nettype wire

>>> hdl/wheel_command_report_encoder.sv
`default_nettype none
// channel   direction  handshake         payload
// req_      in         push / full       command, range_degrees, amount, led_index, led_on
// rsp_      out        empty / pop       byte0..byte6, is_report, last, current_range, led_mask
// csr_      in         we (no wait)      index 0 low range limit, 1 high limit; wdata 16 bit
//
// One command is accepted per cycle while full is low; the back end emits one response
// per cycle while pop keeps up, so a command yields 0 to 4 responses (set range 3, LED
// init 4, dropped command 0, others 1) and that report sequencer sets the sustained rate.
// A result passes the front stage register, the job queue and the back end output register.
// Synchronous reset clears the job queue and state; no clearing pass. A stalled rsp_pop
// backs up the 4-entry job queue and then the front stage, which raises full.
module wheel_command_report_encoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [2:0]        req_command,
   input  wire logic [15:0]       req_range_degrees,
   input  wire logic signed [15:0] req_amount,
   input  wire logic [3:0]        req_led_index,
   input  wire logic              req_led_on,
   output logic                   empty,
   input  wire logic              pop,
   output logic [7:0]             rsp_byte0,
   output logic [7:0]             rsp_byte1,
   output logic [7:0]             rsp_byte2,
   output logic [7:0]             rsp_byte3,
   output logic [7:0]             rsp_byte4,
   output logic [7:0]             rsp_byte5,
   output logic [7:0]             rsp_byte6,
   output logic                   rsp_is_report,
   output logic                   rsp_last,
   output logic [15:0]            rsp_current_range,
   output logic [8:0]             rsp_led_mask,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [15:0]       csr_wdata
);

   wcre_pkg::job_type wr_job, rd_job;
   logic q_push, q_full, q_pop, q_empty;

   wcre_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (push),
      .req_full          (full),
      .req_command       (req_command),
      .req_range_degrees (req_range_degrees),
      .req_amount        (req_amount),
      .req_led_index     (req_led_index),
      .req_led_on        (req_led_on),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_push            (q_push),
      .q_job             (wr_job),
      .q_full            (q_full)
   );

   wcre_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_job (wr_job),
      .full   (q_full),
      .pop    (q_pop),
      .rd_job (rd_job),
      .empty  (q_empty)
   );

   wcre_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job               (rd_job),
      .job_empty         (q_empty),
      .job_pop           (q_pop),
      .rsp_empty         (empty),
      .rsp_pop           (pop),
      .rsp_byte0         (rsp_byte0),
      .rsp_byte1         (rsp_byte1),
      .rsp_byte2         (rsp_byte2),
      .rsp_byte3         (rsp_byte3),
      .rsp_byte4         (rsp_byte4),
      .rsp_byte5         (rsp_byte5),
      .rsp_byte6         (rsp_byte6),
      .rsp_is_report     (rsp_is_report),
      .rsp_last          (rsp_last),
      .rsp_current_range (rsp_current_range),
      .rsp_led_mask      (rsp_led_mask)
   );

endmodule
`default_nettype wire
